FILE: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the packet stream deframer.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Header parser position: header byte index 0..4, then payload.
    localparam int POS_W = 3;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_FLAGS   = 3'd0;
    localparam pos_t POS_ID_HI   = 3'd1;
    localparam pos_t POS_ID_LO   = 3'd2;
    localparam pos_t POS_LEN_HI  = 3'd3;
    localparam pos_t POS_LEN_LO  = 3'd4;
    localparam pos_t POS_PAYLOAD = 3'd5;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 4;
    localparam int QOS_W   = 2;
    localparam int WORD_W  = 16;

    // Result tdata: type, qos, dup, id, length, payload byte, one pad bit.
    localparam int M_FIELDS_W = TYPE_W + QOS_W + 1 + WORD_W + WORD_W + BYTE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] payload_length;
        logic [WORD_W-1:0] packet_id;
        logic              dup_flag;
        logic [QOS_W-1:0]  qos_level;
        logic [TYPE_W-1:0] msg_type;
    } result_t;

endpackage

FILE: rtl/packet_stream_deframer.sv
// ----------------------------------------------------------------------------
// packet_stream_deframer
// Splits a byte stream into packets with a five-byte header and emits one
// item per payload byte, or a single empty item for a zero-length packet.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Item contents
//  s_       in         tdata: data_byte[7:0]; tuser: body_start
//  m_       out        tdata: msg_type, qos_level, dup_flag, packet_id,
//                      payload_length, payload_byte (low bits first);
//                      tuser: has_byte; tlast: packet_last
//
// One byte is taken per clock unless a stalled result holds a full input
// register. Each byte is held in the input register and is then parsed into
// the result register, where its result can be taken. A stalled result holds
// the parse stage, and the input side keeps accepting until the input
// register is full. Reset (aresetn low, synchronous) empties both registers
// and returns the parser to the flags byte.
module packet_stream_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] body_start

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psd_pkg::M_TDATA_W-1:0] m_tdata,   // [3:0] msg_type, [5:4] qos_level,
                                                     // [6] dup_flag, [22:7] packet_id,
                                                     // [38:23] payload_length,
                                                     // [46:39] payload_byte, [47] zero
    output logic                          m_tuser,   // [0] has_byte
    output logic                          m_tlast    // packet_last
);

    // Input register.
    logic                          in_valid_reg;
    logic [psd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_start_reg;

    // Parser state.
    psd_pkg::pos_t                 pos_reg,    pos_next;
    logic [psd_pkg::BYTE_W-1:0]    flags_reg,  flags_next;
    logic [psd_pkg::WORD_W-1:0]    id_reg,     id_next;
    logic [psd_pkg::WORD_W-1:0]    len_reg,    len_next;
    logic [psd_pkg::WORD_W-1:0]    remain_reg, remain_next;

    // Result register.
    logic                          out_valid_reg;
    psd_pkg::result_t              out_data_reg;
    logic                          out_has_reg;
    logic                          out_last_reg;

    logic                          advance;
    logic                          emit;
    logic                          emit_has;
    logic                          emit_last;
    psd_pkg::pos_t                 pos_cur;
    logic [psd_pkg::WORD_W-1:0]    remain_dec;
    psd_pkg::result_t              result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Parse one byte. The result uses the header registers as updated by
    // this byte, which matters only for the low length byte.
    always_comb begin
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        emit        = 1'b0;
        emit_has    = 1'b0;
        emit_last   = 1'b0;

        if (in_start_reg || pos_reg > psd_pkg::POS_PAYLOAD) begin
            pos_cur = psd_pkg::POS_FLAGS;
        end else begin
            pos_cur = pos_reg;
        end

        remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

        unique case (pos_cur)
            psd_pkg::POS_FLAGS: begin
                flags_next = in_byte_reg;
                pos_next   = psd_pkg::POS_ID_HI;
            end
            psd_pkg::POS_ID_HI: begin
                id_next  = {in_byte_reg, psd_pkg::BYTE_W'(0)};
                pos_next = psd_pkg::POS_ID_LO;
            end
            psd_pkg::POS_ID_LO: begin
                id_next  = {id_reg[psd_pkg::WORD_W-1:psd_pkg::BYTE_W], in_byte_reg};
                pos_next = psd_pkg::POS_LEN_HI;
            end
            psd_pkg::POS_LEN_HI: begin
                len_next = {in_byte_reg, psd_pkg::BYTE_W'(0)};
                pos_next = psd_pkg::POS_LEN_LO;
            end
            psd_pkg::POS_LEN_LO: begin
                len_next    = {len_reg[psd_pkg::WORD_W-1:psd_pkg::BYTE_W], in_byte_reg};
                remain_next = len_next;
                if (len_next == '0) begin
                    pos_next  = psd_pkg::POS_FLAGS;
                    emit      = 1'b1;
                    emit_last = 1'b1;
                end else begin
                    pos_next = psd_pkg::POS_PAYLOAD;
                end
            end
            default: begin
                remain_next = remain_dec;
                emit        = 1'b1;
                emit_has    = 1'b1;
                emit_last   = (remain_dec == '0);
                pos_next    = emit_last ? psd_pkg::POS_FLAGS : psd_pkg::POS_PAYLOAD;
            end
        endcase

        result.msg_type       = flags_next[7:4];
        result.qos_level      = flags_next[3:2];
        result.dup_flag       = flags_next[1];
        result.packet_id      = id_next;
        result.payload_length = len_next;
        result.payload_byte   = emit_has ? in_byte_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= psd_pkg::POS_FLAGS;
            flags_reg     <= '0;
            id_reg        <= '0;
            len_reg       <= '0;
            remain_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                pos_reg       <= pos_next;
                flags_reg     <= flags_next;
                id_reg        <= id_next;
                len_reg       <= len_next;
                remain_reg    <= remain_next;
                out_valid_reg <= emit;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && emit) begin
            out_data_reg <= result;
            out_has_reg  <= emit_has;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = psd_pkg::M_TDATA_W'(out_data_reg);
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: tb/tb_packet_stream_deframer.sv
// ----------------------------------------------------------------------------
// tb_packet_stream_deframer
// Self-checking bench for the packet stream deframer. A short table of byte
// items covers empty and one-byte packets, extreme header values and restarts
// part-way through a header and a payload. Random bodies of well-formed packets
// follow, mixed with truncated packets and stray bytes. The table gives its
// own results, a local parser predicts the rest; results are compared field
// by field as they leave. Both sides stall in random bursts until CALM_FROM.
// ----------------------------------------------------------------------------
module tb_packet_stream_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             last;
        logic             has;
        psd_pkg::result_t r;
    } frame_item_t;

    typedef struct {
        logic [7:0]  b;
        logic        st;
        logic        pin;
        frame_item_t want;
    } byte_row_t;

    localparam int N_ITEMS   = 1050;
    localparam int CALM_FROM = 900;
    localparam int N_DIRECT  = 25;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'h00;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [psd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    // Local copy of the parser state.
    psd_pkg::pos_t hdr_pos = psd_pkg::POS_FLAGS;
    logic [7:0]    flags_q = '0;
    logic [15:0]   id_q    = '0;
    logic [15:0]   len_q   = '0;
    logic [15:0]   left_q  = '0;

    frame_item_t pending_q[$];
    byte_row_t   dir_tab[N_DIRECT];
    int          n_err       = 0;
    int          n_sent      = 0;
    int          stall_left  = 0;
    bit          idle_en     = 1'b1;
    bit          restart_due = 1'b1;

    packet_stream_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic frame_item_t result_of(input logic [3:0] ty, input logic [1:0] qos,
                                              input logic dup, input logic [15:0] id,
                                              input logic [15:0] len, input logic [7:0] pb,
                                              input logic has, input logic last);
        frame_item_t f;
        f.r.msg_type       = ty;
        f.r.qos_level      = qos;
        f.r.dup_flag       = dup;
        f.r.packet_id      = id;
        f.r.payload_length = len;
        f.r.payload_byte   = pb;
        f.has              = has;
        f.last             = last;
        return f;
    endfunction

    function automatic byte_row_t row(input logic [7:0] b, input logic st);
        byte_row_t t;
        t.b    = b;
        t.st   = st;
        t.pin  = 1'b0;
        t.want = '0;
        return t;
    endfunction

    function automatic byte_row_t pinned(input logic [7:0] b, input logic st,
                                         input frame_item_t want);
        byte_row_t t;
        t.b    = b;
        t.st   = st;
        t.pin  = 1'b1;
        t.want = want;
        return t;
    endfunction

    // Advances the local parser by one byte; returns 1 when the byte yields a result.
    function automatic logic deframe_byte(input logic [7:0] b, input logic st,
                                          output frame_item_t res);
        psd_pkg::pos_t p;
        p   = hdr_pos;
        res = '0;
        if (st || p > psd_pkg::POS_PAYLOAD) begin
            p = psd_pkg::POS_FLAGS;
        end
        case (p)
            psd_pkg::POS_FLAGS: begin
                flags_q = b;
                hdr_pos = psd_pkg::POS_ID_HI;
                return 1'b0;
            end
            psd_pkg::POS_ID_HI: begin
                id_q    = {b, 8'h00};
                hdr_pos = psd_pkg::POS_ID_LO;
                return 1'b0;
            end
            psd_pkg::POS_ID_LO: begin
                id_q[7:0] = b;
                hdr_pos   = psd_pkg::POS_LEN_HI;
                return 1'b0;
            end
            psd_pkg::POS_LEN_HI: begin
                len_q   = {b, 8'h00};
                hdr_pos = psd_pkg::POS_LEN_LO;
                return 1'b0;
            end
            psd_pkg::POS_LEN_LO: begin
                len_q[7:0] = b;
                left_q     = len_q;
                if (len_q == 16'd0) begin
                    hdr_pos = psd_pkg::POS_FLAGS;
                    res = result_of(flags_q[7:4], flags_q[3:2], flags_q[1], id_q, len_q,
                                    8'h00, 1'b0, 1'b1);
                    return 1'b1;
                end
                hdr_pos = psd_pkg::POS_PAYLOAD;
                return 1'b0;
            end
            default: begin
                if (left_q != 16'd0) begin
                    left_q = left_q - 16'd1;
                end
                hdr_pos = (left_q == 16'd0) ? psd_pkg::POS_FLAGS : psd_pkg::POS_PAYLOAD;
                res = result_of(flags_q[7:4], flags_q[3:2], flags_q[1], id_q, len_q,
                                b, 1'b1, left_q == 16'd0);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] e,
                                        input logic [15:0] a);
        if (a !== e) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
            n_err++;
        end
    endfunction

    // Offers one item, waits for it to be taken and records what it should yield.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic pin,
                             input frame_item_t want);
        frame_item_t res;
        logic        got;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        got = deframe_byte(b, st, res);
        if (pin) begin
            pending_q.push_back(want);
        end else if (got) begin
            pending_q.push_back(res);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_q.size() != 0);
    endtask

    task automatic send_packet();
        logic [7:0]  hdr[5];
        int unsigned plen;
        int unsigned n_hdr;
        int unsigned n_pay;
        logic        st;
        st = restart_due || ($urandom_range(0, 4) == 0);
        restart_due = 1'b0;
        case ($urandom_range(0, 99)) inside
            [0:14]:  plen = 0;
            [15:79]: plen = $urandom_range(1, 8);
            [80:91]: plen = $urandom_range(9, 40);
            default: plen = $urandom_range(0, 65535);
        endcase
        hdr[0] = 8'($urandom);
        hdr[1] = 8'($urandom);
        hdr[2] = 8'($urandom);
        hdr[3] = plen[15:8];
        hdr[4] = plen[7:0];
        n_hdr = 5;
        n_pay = plen;
        // Long packets are cut short, as are some headers and payloads; a restart then abandons them.
        if (plen > 40) begin
            n_pay = $urandom_range(0, 6);
            restart_due = 1'b1;
        end else if ($urandom_range(0, 99) < 6) begin
            n_hdr = $urandom_range(1, 4);
            n_pay = 0;
            restart_due = 1'b1;
        end else if (plen > 1 && $urandom_range(0, 99) < 6) begin
            n_pay = $urandom_range(1, plen - 1);
            restart_due = 1'b1;
        end
        for (int i = 0; i < n_hdr; i++) begin
            send_byte(hdr[i], st && i == 0, 1'b0, '0);
        end
        for (int i = 0; i < n_pay; i++) begin
            send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end
        // Occasional stray bytes between packets.
        if ($urandom_range(0, 99) < 4) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom), 1'b0, '0);
            restart_due = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_item_t      want;
        psd_pkg::result_t got;
        got = m_tdata[psd_pkg::M_FIELDS_W-1:0];
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result with none expected: tdata 0x%0h", m_tdata);
                n_err++;
            end else begin
                want = pending_q.pop_front();
                check_field("msg_type", 16'(want.r.msg_type), 16'(got.msg_type));
                check_field("qos_level", 16'(want.r.qos_level), 16'(got.qos_level));
                check_field("dup_flag", 16'(want.r.dup_flag), 16'(got.dup_flag));
                check_field("packet_id", want.r.packet_id, got.packet_id);
                check_field("payload_length", want.r.payload_length, got.payload_length);
                check_field("payload_byte", 16'(want.r.payload_byte), 16'(got.payload_byte));
                check_field("has_byte", 16'(want.has), 16'(m_tuser));
                check_field("packet_last", 16'(want.last), 16'(m_tlast));
                check_field("tdata_pad", 16'd0, 16'(m_tdata >> psd_pkg::M_FIELDS_W));
            end
        end
    end

    initial begin
        dir_tab = '{
            // Empty packet with every flags and id bit set.
            row(8'hFF, 1'b1), row(8'hFF, 1'b0), row(8'hFF, 1'b0), row(8'h00, 1'b0),
            pinned(8'h00, 1'b0, result_of(4'hF, 2'd3, 1'b1, 16'hFFFF, 16'h0000,
                                          8'h00, 1'b0, 1'b1)),
            // One-byte payload behind all-zero flags and id.
            row(8'h00, 1'b1), row(8'h00, 1'b0), row(8'h00, 1'b0), row(8'h00, 1'b0),
            row(8'h01, 1'b0),
            pinned(8'hFF, 1'b0, result_of(4'h0, 2'd0, 1'b0, 16'h0000, 16'h0001,
                                          8'hFF, 1'b1, 1'b1)),
            // Three-byte payload abandoned after two bytes.
            row(8'hA5, 1'b1), row(8'h12, 1'b0), row(8'h34, 1'b0), row(8'h00, 1'b0),
            row(8'h03, 1'b0),
            pinned(8'h11, 1'b0, result_of(4'hA, 2'd1, 1'b0, 16'h1234, 16'h0003,
                                          8'h11, 1'b1, 1'b0)),
            pinned(8'h22, 1'b0, result_of(4'hA, 2'd1, 1'b0, 16'h1234, 16'h0003,
                                          8'h22, 1'b1, 1'b0)),
            // Header abandoned after its id high byte.
            row(8'hC3, 1'b1), row(8'h99, 1'b0),
            // Fresh body holding an empty packet.
            row(8'h5A, 1'b1), row(8'hAB, 1'b0), row(8'hCD, 1'b0), row(8'h00, 1'b0),
            pinned(8'h00, 1'b0, result_of(4'h5, 2'd2, 1'b1, 16'hABCD, 16'h0000,
                                          8'h00, 1'b0, 1'b1))
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].b, dir_tab[i].st, dir_tab[i].pin, dir_tab[i].want);
        end
        // Let the pipeline empty completely before the random traffic.
        drain();

        while (n_sent < N_ITEMS) begin
            if (n_sent >= CALM_FROM) begin
                idle_en = 1'b0;
            end
            send_packet();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (n_err == 0) begin
            $display("tb_packet_stream_deframer: done, clean");
        end else begin
            $display("tb_packet_stream_deframer: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_packet_stream_deframer: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/psd_pkg.sv
rtl/packet_stream_deframer.sv
tb/tb_packet_stream_deframer.sv
